>>> rtl/core/u2u_pkg.sv
// shared types and constants for the utf-8 to utf-16 decoder
package u2u_pkg;

    // largest legal code point and surrogate bases
    localparam logic [20:0] MAX_POINT = 21'h10FFFF;
    localparam logic [20:0] PLANE_ONE = 21'h010000;
    localparam logic [15:0] HIGH_SURR = 16'hD800;
    localparam logic [15:0] LOW_SURR  = 16'hDC00;
    localparam logic [15:0] BMP_LAST  = 16'hFFFF;
    localparam logic [7:0]  LAST_LEAD = 8'hF4;
    localparam logic [5:0]  CONT_MASK = 6'h3F;

    // what the back end has to produce for one queued job
    typedef enum logic [1:0] {
        JOB_UNIT  = 2'd0,
        JOB_PAIR  = 2'd1,
        JOB_ERROR = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [20:0] point;
    } job_t;

endpackage

>>> rtl/core/u2u_front.sv
// front end: takes utf-8 bytes, gathers code points, queues jobs
module u2u_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_stall,
    input  logic [7:0]     data_byte,
    output logic           job_push,
    output u2u_pkg::job_t  job
);

    logic [20:0] partial_reg;
    logic [20:0] partial_next;
    logic [1:0]  due_reg;
    logic [1:0]  due_next;
    logic        failed_reg;
    logic        failed_next;
    logic        accept;
    logic [20:0] shifted;
    logic [1:0]  due_dec;

    assign accept  = in_valid && !in_stall;
    assign shifted = {partial_reg[14:0], data_byte[5:0] & u2u_pkg::CONT_MASK};
    assign due_dec = due_reg - 2'd1;

    // decode one byte against the gathered state
    always_comb
    begin
        partial_next = partial_reg;
        due_next     = due_reg;
        failed_next  = failed_reg;
        job_push     = 1'b0;
        job.kind     = u2u_pkg::JOB_UNIT;
        job.point    = '0;
        if (accept && !failed_reg)
        begin
            if (due_reg == 2'd0)
            begin
                priority if (data_byte <= 8'h7F)
                begin
                    job_push     = 1'b1;
                    job.point    = {13'd0, data_byte};
                    partial_next = '0;
                end
                else if (data_byte >= 8'hC0 && data_byte <= 8'hDF)
                begin
                    partial_next = {16'd0, data_byte[4:0]};
                    due_next     = 2'd1;
                end
                else if (data_byte >= 8'hE0 && data_byte <= 8'hEF)
                begin
                    partial_next = {17'd0, data_byte[3:0]};
                    due_next     = 2'd2;
                end
                else if (data_byte >= 8'hF0 && data_byte <= u2u_pkg::LAST_LEAD)
                begin
                    partial_next = {18'd0, data_byte[2:0]};
                    due_next     = 2'd3;
                end
                else
                begin
                    job_push     = 1'b1;
                    job.kind     = u2u_pkg::JOB_ERROR;
                    failed_next  = 1'b1;
                    partial_next = '0;
                    due_next     = 2'd0;
                end
            end
            else
            begin
                priority if (data_byte[7:6] != 2'b10 || shifted > u2u_pkg::MAX_POINT)
                begin
                    job_push     = 1'b1;
                    job.kind     = u2u_pkg::JOB_ERROR;
                    failed_next  = 1'b1;
                    partial_next = '0;
                    due_next     = 2'd0;
                end
                else if (due_dec == 2'd0)
                begin
                    job_push     = 1'b1;
                    job.point    = shifted;
                    job.kind     = (shifted <= {5'd0, u2u_pkg::BMP_LAST}) ?
                                   u2u_pkg::JOB_UNIT : u2u_pkg::JOB_PAIR;
                    partial_next = '0;
                    due_next     = 2'd0;
                end
                else
                begin
                    partial_next = shifted;
                    due_next     = due_dec;
                end
            end
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            due_reg     <= '0;
            failed_reg  <= 1'b0;
        end
        else
        begin
            partial_reg <= partial_next;
            due_reg     <= due_next;
            failed_reg  <= failed_next;
        end
    end

`ifndef SYNTHESIS
    // once failed, the decoder stays failed until reset
    assert property (@(posedge clk) disable iff (!rst_n) failed_reg |=> failed_reg)
        else $error("failed flag cleared without reset");

    // a failed decoder holds no partial character
    assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> (due_reg == 2'd0 && partial_reg == 21'd0))
        else $error("partial state left after error");
`endif

endmodule

>>> rtl/core/u2u_queue.sv
// short job queue between the front and back ends
module u2u_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  u2u_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output u2u_pkg::job_t  head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u2u_pkg::job_t      slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

`ifndef SYNTHESIS
    // the fill count never runs past the depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("queue overfilled");

    // a push is never offered to a full queue
    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("push into full queue");
`endif

endmodule

>>> rtl/core/u2u_back.sv
// back end: turns queued jobs into utf-16 output beats
module u2u_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  u2u_pkg::job_t  head_job,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [15:0]    code_unit,
    output logic           last_unit,
    output logic           error
);

    logic        valid_reg;
    logic        valid_next;
    logic [15:0] unit_reg;
    logic [15:0] unit_next;
    logic        last_reg;
    logic        last_next;
    logic        error_reg;
    logic        error_next;
    logic        low_pending_reg;
    logic        low_pending_next;
    logic [9:0]  low_bits_reg;
    logic [9:0]  low_bits_next;
    logic        load;
    logic [20:0] offset;

    assign load   = !valid_reg || !out_stall;
    assign offset = head_job.point - u2u_pkg::PLANE_ONE;

    // choose the next output beat
    always_comb
    begin
        valid_next       = valid_reg;
        unit_next        = unit_reg;
        last_next        = last_reg;
        error_next       = error_reg;
        low_pending_next = low_pending_reg;
        low_bits_next    = low_bits_reg;
        pop              = 1'b0;
        if (load)
        begin
            if (low_pending_reg)
            begin
                valid_next       = 1'b1;
                unit_next        = u2u_pkg::LOW_SURR | {6'd0, low_bits_reg};
                last_next        = 1'b1;
                error_next       = 1'b0;
                low_pending_next = 1'b0;
            end
            else if (head_valid)
            begin
                pop        = 1'b1;
                valid_next = 1'b1;
                unique case (head_job.kind)
                    u2u_pkg::JOB_UNIT:
                    begin
                        unit_next  = head_job.point[15:0];
                        last_next  = 1'b1;
                        error_next = 1'b0;
                    end
                    u2u_pkg::JOB_PAIR:
                    begin
                        unit_next        = u2u_pkg::HIGH_SURR | {6'd0, offset[19:10]};
                        last_next        = 1'b0;
                        error_next       = 1'b0;
                        low_pending_next = 1'b1;
                        low_bits_next    = head_job.point[9:0];
                    end
                    u2u_pkg::JOB_ERROR:
                    begin
                        unit_next  = '0;
                        last_next  = 1'b1;
                        error_next = 1'b1;
                    end
                    default:
                    begin
                        valid_next = 1'b0;
                    end
                endcase
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= 1'b0;
            low_pending_reg <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            low_pending_reg <= low_pending_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        unit_reg     <= unit_next;
        last_reg     <= last_next;
        error_reg    <= error_next;
        low_bits_reg <= low_bits_next;
    end

    assign out_valid = valid_reg;
    assign code_unit = unit_reg;
    assign last_unit = last_reg;
    assign error     = error_reg;

`ifndef SYNTHESIS
    // a pending low surrogate always sits behind a shown high surrogate
    assert property (@(posedge clk) disable iff (!rst_n)
        low_pending_reg |-> (valid_reg && !last_reg && !error_reg
                             && unit_reg[15:10] == u2u_pkg::HIGH_SURR[15:10]))
        else $error("low surrogate pending without high surrogate");

    // an error beat carries a zero unit and closes the character
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && error_reg) |-> (last_reg && unit_reg == 16'd0))
        else $error("malformed error beat");
`endif

endmodule

>>> rtl/core/utf8_to_utf16_decoder_unit.sv
// top level of the utf-8 to utf-16 decoder
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  data_byte[7:0]
//  out      output     out_valid/out_stall code_unit[15:0], last_unit, error
//
// one byte is taken per cycle while the job queue has room
// a unit beat moves from the queue head into the output register once it is
// free; a surrogate pair holds it for two beats, which the queue absorbs
// in_stall follows only the queue fill count, never out_stall directly
// reset clears the decoder state, queue and output valid; no clearing pass
module utf8_to_utf16_decoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] code_unit,
    output logic        last_unit,
    output logic        error
);

    logic          job_push;
    u2u_pkg::job_t job;
    logic          queue_full;
    logic          head_valid;
    u2u_pkg::job_t head_job;
    logic          pop;

    assign in_stall = queue_full;

    // byte decode
    u2u_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .job_push  (job_push),
        .job       (job)
    );

    // decoupling queue
    u2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // unit output
    u2u_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_unit  (code_unit),
        .last_unit  (last_unit),
        .error      (error)
    );

endmodule
